>>> rtl/frnc_pkg.sv
`default_nettype none
package frnc_pkg;

   // Internal word width and defaults
   localparam int DATA_WIDTH        = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int LIMIT_WIDTH       = 6;
   localparam int LEAD_WIDTH        = $clog2(DATA_WIDTH);

   localparam logic [LIMIT_WIDTH-1:0] ITER_LIMIT_RESET = LIMIT_WIDTH'(8);

   typedef logic signed [DATA_WIDTH-1:0]   word_type;
   typedef logic signed [DATA_WIDTH:0]     sum_type;
   typedef logic signed [2*DATA_WIDTH-1:0] wide_type;

   localparam word_type WORD_MAX = word_type'({1'b0, {(DATA_WIDTH-1){1'b1}}});
   localparam word_type WORD_MIN = word_type'({1'b1, {(DATA_WIDTH-1){1'b0}}});

   // Saturate a double-width value to the word range
   function automatic word_type clamp_wide(input wide_type a);
      word_type r;
      r = a[DATA_WIDTH-1:0];
      if (!a[2*DATA_WIDTH-1] && (|a[2*DATA_WIDTH-2:DATA_WIDTH-1])) begin
         r = WORD_MAX;
      end else if (a[2*DATA_WIDTH-1] && !(&a[2*DATA_WIDTH-2:DATA_WIDTH-1])) begin
         r = WORD_MIN;
      end
      return r;
   endfunction

   // Saturate a one-bit-grown sum to the word range
   function automatic word_type clamp_sum(input sum_type s);
      word_type r;
      r = s[DATA_WIDTH-1:0];
      if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
         r = s[DATA_WIDTH] ? WORD_MIN : WORD_MAX;
      end
      return r;
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      sum_type s;
      s = sum_type'(a) + sum_type'(b);
      return clamp_sum(s);
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      sum_type s;
      s = sum_type'(a) - sum_type'(b);
      return clamp_sum(s);
   endfunction

   function automatic word_type sat_neg(input word_type a);
      word_type r;
      r = (a == WORD_MIN) ? WORD_MAX : -a;
      return r;
   endfunction

   // Position of the leading one; zero input gives zero
   function automatic logic [LEAD_WIDTH-1:0] lead_one(input word_type a);
      logic [LEAD_WIDTH-1:0] pos;
      pos = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (a[i]) begin
            pos = LEAD_WIDTH'(i);
         end
      end
      return pos;
   endfunction

endpackage
`default_nettype wire

>>> rtl/frnc_mul.sv
`default_nettype none
module frnc_mul
   import frnc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     mul_enable,
   input  wire word_type op_a,
   input  wire word_type op_b,
   output wide_type      product_ff
);

   wide_type product_in;

   // Full signed product, registered
   assign product_in = wide_type'(op_a) * wide_type'(op_b);

   always_ff @(posedge clock) begin
      if (mul_enable) begin
         product_ff <= product_in;
      end
   end

endmodule
`default_nettype wire

>>> rtl/fixed_point_reciprocal_newton_core.sv
// Fixed-point reciprocal by Newton-Raphson refinement.
// Input channel req_valid/req_ready carries req_divisor, a signed value with
// FRAC_BITS fraction bits. Result channel rsp_valid/rsp_ready carries
// rsp_reciprocal (same format) and rsp_divide_by_zero.
// csr_write_enable/csr_write_data set the iteration limit (reset value 8);
// write it only while the core is idle.
// Each item: the magnitude is taken in the accepting cycle, then the SEED state
// seeds the guess from the leading-one position, each Newton step runs through
// MUL1, SUB, MUL2 and ADD on the one shared 32x32 multiplier (d*x, error, x*e,
// update), and the FINISH state applies the sign and loads the output register.
// A zero divisor goes from the accepting cycle straight to FINISH. The
// multiplier loop sets the rate: one item at a time, and a new item is accepted
// only after the last one has left FINISH.
// req_ready is high only when the sequencer is idle. The output register holds
// a finished item while rsp_ready is low; the next item may be accepted and
// computed meanwhile, and it waits in the last step until the register frees.
// Reset (synchronous, active high) drops any item in flight, clears rsp_valid
// and restores the iteration limit.
`default_nettype none
module fixed_point_reciprocal_newton_core
   import frnc_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [31:0]     req_divisor,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic signed [31:0]          rsp_reciprocal,
   output logic                        rsp_divide_by_zero,
   input  wire logic                   csr_write_enable,
   input  wire logic [LIMIT_WIDTH-1:0] csr_write_data
);

   localparam word_type ONE = word_type'(1) << FRAC_BITS;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SEED   = 7'b0000010,
      ST_MUL1   = 7'b0000100,
      ST_SUB    = 7'b0001000,
      ST_MUL2   = 7'b0010000,
      ST_ADD    = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type              state_ff, state_in;
   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic [LIMIT_WIDTH-1:0] count_ff, count_in;
   word_type               d_ff, d_in;
   word_type               x0_ff, x0_in;
   word_type               x1_ff, x1_in;
   word_type               y_ff, y_in;
   logic                   neg_ff, neg_in;
   logic                   dz_ff, dz_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   word_type               rsp_value_ff, rsp_value_in;
   logic                   rsp_dz_ff, rsp_dz_in;

   word_type               in_word;
   word_type               mul_a, mul_b;
   logic                   mul_enable;
   wide_type               product_ff;
   word_type               product_sat;
   word_type               corr;
   word_type               x_next;
   logic [LIMIT_WIDTH:0]   iter_next;
   logic [LEAD_WIDTH-1:0]  lead;
   logic signed [7:0]      seed_exp;
   word_type               seed;
   logic                   out_free;

   // Shared multiplier
   assign mul_enable = (state_ff == ST_MUL1) || (state_ff == ST_MUL2);
   assign mul_a      = (state_ff == ST_MUL1) ? d_ff : x0_ff;
   assign mul_b      = (state_ff == ST_MUL1) ? x0_ff : y_ff;

   frnc_mul u_mul (
      .clock      (clock),
      .mul_enable (mul_enable),
      .op_a       (mul_a),
      .op_b       (mul_b),
      .product_ff (product_ff)
   );

   // Floor shift of the product back to the word format
   assign product_sat = clamp_wide(product_ff >>> FRAC_BITS);
   assign corr        = product_sat;
   assign x_next      = sat_add(x0_ff, corr);
   assign iter_next   = {1'b0, count_ff} + (LIMIT_WIDTH+1)'(1);

   // Seed guess 2^(2F-b-1) from the leading one of the magnitude
   assign lead     = lead_one(d_ff);
   assign seed_exp = 8'(2 * FRAC_BITS - 1) - 8'(lead);

   always_comb begin
      if (seed_exp < 0) begin
         seed = '0;
      end else if (seed_exp >= 8'(DATA_WIDTH - 1)) begin
         seed = WORD_MAX;
      end else begin
         seed = word_type'(1) << seed_exp[LEAD_WIDTH-1:0];
      end
   end

   assign in_word  = word_type'(req_divisor);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      d_in         = d_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      y_in         = y_ff;
      neg_in       = neg_ff;
      dz_in        = dz_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_dz_in    = rsp_dz_ff;

      // Drop the output item once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in = in_word[DATA_WIDTH-1];
               if (in_word == '0) begin
                  dz_in    = 1'b1;
                  neg_in   = 1'b0;
                  x1_in    = WORD_MAX;
                  state_in = ST_FINISH;
               end else begin
                  dz_in    = 1'b0;
                  d_in     = (in_word == WORD_MIN) ? WORD_MAX :
                             (in_word[DATA_WIDTH-1] ? -in_word : in_word);
                  state_in = ST_SEED;
               end
            end
         end
         ST_SEED: begin
            x0_in    = seed;
            count_in = '0;
            if (limit_ff == '0) begin
               x1_in    = '0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_SUB;
         end
         ST_SUB: begin
            // Error term e = one - d*x
            y_in     = sat_sub(ONE, product_sat);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_ADD;
         end
         ST_ADD: begin
            // Update x, stop on a zero error or correction or at the limit
            x1_in    = x_next;
            x0_in    = x_next;
            count_in = iter_next[LIMIT_WIDTH-1:0];
            if ((y_ff == '0) || (corr == '0) || (iter_next == {1'b0, limit_ff})) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_FINISH: begin
            // Apply the sign and load the output register when free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = neg_ff ? sat_neg(x1_ff) : x1_ff;
               rsp_dz_in    = dz_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limit_ff     <= ITER_LIMIT_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      count_ff     <= count_in;
      d_ff         <= d_in;
      x0_ff        <= x0_in;
      x1_ff        <= x1_in;
      y_ff         <= y_in;
      neg_ff       <= neg_in;
      dz_ff        <= dz_in;
      rsp_value_ff <= rsp_value_in;
      rsp_dz_ff    <= rsp_dz_in;
   end

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reciprocal     = rsp_value_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule
`default_nettype wire

>>> sim/tb_fixed_point_reciprocal_newton_core.sv
`default_nettype none
module tb_fixed_point_reciprocal_newton_core;
   import frnc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     FRAC        = FRAC_BITS_DEFAULT;
   localparam longint ONE         = longint'(1) << FRAC;
   localparam longint WMAX        = longint'(WORD_MAX);
   localparam longint WMIN        = longint'(WORD_MIN);
   localparam int     CYCLE_LIMIT = 600000;
   localparam int     TAIL_CYCLES = 300;

   typedef struct {
      word_type reciprocal;
      logic     divide_by_zero;
   } recip_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   word_type               req_divisor = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   word_type               rsp_reciprocal;
   logic                   rsp_divide_by_zero;
   logic                   csr_write_enable = 1'b0;
   logic [LIMIT_WIDTH-1:0] csr_write_data = '0;

   // Shadow copy of the iteration limit
   logic [LIMIT_WIDTH-1:0] step_limit = ITER_LIMIT_RESET;

   word_type         divisor_queue[$];
   recip_result_type pending_reciprocals[$];
   logic             req_held = 1'b0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   int               error_count = 0;
   int               cycle_count = 0;

   word_type corner_divisors [18] = '{
      32'sh00000000, 32'sh00000001, 32'shFFFFFFFF, 32'sh7FFFFFFF,
      32'sh80000000, 32'sh80000001, 32'sh00010000, 32'shFFFF0000,
      32'sh00008000, 32'sh00000002, 32'sh00000003, 32'sh00018000,
      32'sh40000000, 32'shC0000000, 32'sh00000100, 32'sh12345678,
      32'shEDCBA988, 32'sh0000FFFF
   };

   fixed_point_reciprocal_newton_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_reciprocal     (rsp_reciprocal),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Clamp to the signed word range
   function automatic longint clamp_word(input longint v);
      if (v > WMAX) return WMAX;
      if (v < WMIN) return WMIN;
      return v;
   endfunction

   // Fixed-point product, floored, then clamped
   function automatic longint fx_product(input longint a, input longint b);
      longint p;
      p = a * b;
      return clamp_word(p >>> FRAC);
   endfunction

   // Seed from the leading one, refine, then restore the sign
   function automatic recip_result_type newton_reciprocal(input word_type divisor,
                                                           input logic [LIMIT_WIDTH-1:0] steps);
      recip_result_type r;
      longint           mag, x, x_next, err, corr;
      int               lead, shift;
      logic             negative;
      r.divide_by_zero = 1'b0;
      if (divisor == 0) begin
         r.reciprocal = WORD_MAX;
         r.divide_by_zero = 1'b1;
         return r;
      end
      negative = divisor < 0;
      if (divisor == WORD_MIN) begin
         mag = WMAX;
      end else begin
         mag = negative ? -longint'(divisor) : longint'(divisor);
      end
      lead = -1;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (mag[i]) lead = i;
      end
      shift = FRAC - lead - 1;
      if (shift > 0) begin
         x = (FRAC + shift >= DATA_WIDTH - 1) ? WMAX : (longint'(1) << (FRAC + shift));
      end else begin
         x = ONE >> (-shift);
      end
      x_next = 0;
      for (int i = 0; i < steps; i++) begin
         err = clamp_word(ONE - fx_product(mag, x));
         corr = fx_product(x, err);
         x_next = clamp_word(x + corr);
         if (err == 0 || corr == 0) break;
         x = x_next;
      end
      if (negative) x_next = (x_next == WMIN) ? WMAX : -x_next;
      r.reciprocal = word_type'(x_next[DATA_WIDTH-1:0]);
      return r;
   endfunction

   // Spread leading-one positions, with zero and the extremes mixed in
   function automatic word_type random_divisor();
      word_type v;
      case ($urandom_range(0, 15))
         0: v = '0;
         1: v = WORD_MIN;
         2: v = WORD_MAX;
         3: v = word_type'($urandom);
         default: begin
            v = word_type'($urandom >> $urandom_range(0, 31));
            if ($urandom_range(0, 1)) v = -v;
         end
      endcase
      return v;
   endfunction

   // Present the next item, hold it until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_held) begin
         if (divisor_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_divisor <= divisor_queue.pop_front();
            req_held = 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the result side at random
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Predict on each accepted item, check each accepted result
   always @(posedge clock) begin
      recip_result_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (!reset) begin
         if (req_valid && req_ready) begin
            pending_reciprocals.push_back(newton_reciprocal(req_divisor, step_limit));
            req_held = 1'b0;
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_reciprocals.size() == 0) begin
               $display("%0t: result with nothing pending: reciprocal %h flag %b",
                        $time, rsp_reciprocal, rsp_divide_by_zero);
               error_count++;
            end else begin
               want = pending_reciprocals.pop_front();
               if (rsp_reciprocal !== want.reciprocal) begin
                  $display("%0t: reciprocal expected %h actual %h",
                           $time, want.reciprocal, rsp_reciprocal);
                  error_count++;
               end
               if (rsp_divide_by_zero !== want.divide_by_zero) begin
                  $display("%0t: divide_by_zero expected %b actual %b",
                           $time, want.divide_by_zero, rsp_divide_by_zero);
                  error_count++;
               end
            end
         end
      end
   end

   // Block until every queued item is accepted and every result has come
   task automatic wait_for_drain();
      while (divisor_queue.size() != 0 || req_held || pending_reciprocals.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // Write the iteration limit while the core is idle
   task automatic write_limit(input logic [LIMIT_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      step_limit = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One setting of limit, idling and stalling; drain halfway through
   task automatic run_phase(input logic [LIMIT_WIDTH-1:0] new_limit, input int idle_pct,
                            input int stall_pct, input int count);
      wait_for_drain();
      write_limit(new_limit);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2) wait_for_drain();
         divisor_queue.push_back(random_divisor());
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Corner values at the reset limit, no idling
      foreach (corner_divisors[i]) divisor_queue.push_back(corner_divisors[i]);

      run_phase(6'd0,  70,  0,  40);
      run_phase(6'd63,  0, 70,  50);
      run_phase(6'd1,  17, 17,  80);
      run_phase(6'd32,  0,  0,  70);
      run_phase(6'd5,  70,  0, 100);
      run_phase(6'd12,  0, 70, 100);
      run_phase(6'd8,  17, 17,  80);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
rtl/frnc_pkg.sv
rtl/frnc_mul.sv
rtl/fixed_point_reciprocal_newton_core.sv
sim/tb_fixed_point_reciprocal_newton_core.sv
